>>> rtl/core/assert_macros.svh
// Assertion macros used by the back end of the row centroid block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CPRC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define CPRC_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define CPRC_ASSERT(name, prop)
`define CPRC_NEVER(name, cond)
`endif
`endif

>>> rtl/core/cprc_pkg.sv
// Package with the types, constants and codes of the row centroid block.
`default_nettype none
package cprc_pkg;

  localparam int unsigned LineWidth  = 320;
  localparam int unsigned TallyMax   = 511;
  localparam int unsigned TallyCap   = (LineWidth < TallyMax) ? LineWidth : TallyMax;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
  localparam int unsigned SumW       = 18;
  localparam int unsigned DivSteps   = SumW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [2:0] RegMode      = 3'd0;
  localparam logic [2:0] RegDarkThr   = 3'd1;
  localparam logic [2:0] RegRedThr    = 3'd2;
  localparam logic [2:0] RegGreenThr  = 3'd3;
  localparam logic [2:0] RegBlueThr   = 3'd4;
  localparam logic [2:0] RegMinCount  = 3'd5;
  localparam logic [2:0] RegCenterCol = 3'd6;

  typedef enum logic [1:0] {
    ModeDark  = 2'd0,
    ModeRed   = 2'd1,
    ModeGreen = 2'd2,
    ModeBlue  = 2'd3
  } mode_e;

  localparam logic [7:0] DarkThrReset   = 8'd60;
  localparam logic [7:0] RedThrReset    = 8'd100;
  localparam logic [7:0] GreenThrReset  = 8'd60;
  localparam logic [7:0] BlueThrReset   = 8'd70;
  localparam logic [8:0] MinCountReset  = 9'd5;
  localparam logic [8:0] CenterColReset = 9'd160;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] dark_thr;
    logic [7:0] red_thr;
    logic [7:0] green_thr;
    logic [7:0] blue_thr;
    logic [8:0] min_count;
    logic [8:0] center_col;
  } cfg_t;

  typedef struct packed {
    logic            found;
    logic [8:0]      tally;
    logic [SumW-1:0] sum;
  } row_sum_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDivide,
    BkDone
  } back_state_e;

  function automatic logic dominant(input logic [7:0] t, input logic [7:0] thr,
                                    input logic [7:0] a, input logic [7:0] b);
    logic [9:0] t2;
    logic [9:0] a3;
    logic [9:0] b3;
    t2 = {1'b0, t, 1'b0};
    a3 = {2'b00, a} + {1'b0, a, 1'b0};
    b3 = {2'b00, b} + {1'b0, b, 1'b0};
    return (t > thr) && (t2 > a3) && (t2 > b3);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/cprc_front.sv
// Front end: classifies pixels and accumulates the count and offset sum of a row.
`default_nettype none
module cprc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cprc_pkg::cfg_t    cfg_i,
  input  wire logic              accept_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic [7:0]        luma_i,
  input  wire logic [8:0]        column_i,
  input  wire logic              row_end_i,
  output logic                   q_push_o,
  output cprc_pkg::row_sum_t     q_data_o
);

  logic [8:0]                tally_q, tally_d;
  logic [cprc_pkg::SumW-1:0] sum_q, sum_d;
  logic                      match;
  logic                      take;
  logic [9:0]                offset;
  logic [cprc_pkg::SumW:0]   ext_sum;
  logic [8:0]                tally_new;
  logic [cprc_pkg::SumW-1:0] sum_new;

  always_comb begin
    unique case (cfg_i.mode)
      cprc_pkg::ModeDark:  match = luma_i < cfg_i.dark_thr;
      cprc_pkg::ModeRed:   match = cprc_pkg::dominant(red_i, cfg_i.red_thr, green_i, blue_i);
      cprc_pkg::ModeGreen: match = cprc_pkg::dominant(green_i, cfg_i.green_thr, red_i, blue_i);
      cprc_pkg::ModeBlue:  match = (blue_i > cfg_i.blue_thr) && (blue_i > red_i) &&
                                   (blue_i > green_i);
      default:             match = 1'b0;
    endcase
  end

  always_comb begin
    take    = match && (tally_q < 9'(cprc_pkg::TallyCap));
    offset  = {1'b0, column_i} - {1'b0, cfg_i.center_col};
    ext_sum = {sum_q[cprc_pkg::SumW-1], sum_q} +
              {{(cprc_pkg::SumW - 9){offset[9]}}, offset};
    tally_new = tally_q;
    sum_new   = sum_q;
    if (take) begin
      tally_new = tally_q + 9'd1;
      if (ext_sum[cprc_pkg::SumW] != ext_sum[cprc_pkg::SumW-1]) begin
        sum_new = ext_sum[cprc_pkg::SumW] ? cprc_pkg::SumMin : cprc_pkg::SumMax;
      end else begin
        sum_new = ext_sum[cprc_pkg::SumW-1:0];
      end
    end
    tally_d = tally_q;
    sum_d   = sum_q;
    if (accept_i) begin
      tally_d = row_end_i ? 9'd0 : tally_new;
      sum_d   = row_end_i ? '0 : sum_new;
    end
    q_push_o       = accept_i && row_end_i;
    q_data_o.found = tally_new > cfg_i.min_count;
    q_data_o.tally = tally_new;
    q_data_o.sum   = sum_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      sum_q   <= '0;
    end else begin
      tally_q <= tally_d;
      sum_q   <= sum_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cprc_fifo.sv
// Short queue of finished row totals between the front end and the divider.
`default_nettype none
module cprc_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire cprc_pkg::row_sum_t data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output cprc_pkg::row_sum_t      data_o,
  output logic                    empty_o
);

  cprc_pkg::row_sum_t                mem_q [cprc_pkg::QueueDepth];
  logic [cprc_pkg::QueuePtrW-1:0]    wptr_q, wptr_d;
  logic [cprc_pkg::QueuePtrW-1:0]    rptr_q, rptr_d;
  logic [cprc_pkg::QueueCntW-1:0]    cnt_q, cnt_d;
  logic                              do_push;
  logic                              do_pop;

  function automatic logic [cprc_pkg::QueuePtrW-1:0] next_ptr(
      input logic [cprc_pkg::QueuePtrW-1:0] p);
    logic [cprc_pkg::QueuePtrW-1:0] r;
    if (p == cprc_pkg::QueuePtrW'(cprc_pkg::QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    full_o  = cnt_q == cprc_pkg::QueueCntW'(cprc_pkg::QueueDepth);
    empty_o = cnt_q == '0;
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    wptr_d  = do_push ? next_ptr(wptr_q) : wptr_q;
    rptr_d  = do_pop ? next_ptr(rptr_q) : rptr_q;
    cnt_d   = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
    data_o = mem_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cprc_back.sv
// Back end: divides the offset sum by the count one bit per cycle and holds the result word.
`default_nettype none
`include "assert_macros.svh"
module cprc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire cprc_pkg::row_sum_t q_data_i,
  output logic                    q_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output logic                    found_o,
  output logic signed [9:0]       position_o,
  output logic [8:0]              match_count_o
);

  cprc_pkg::back_state_e            state_q, state_d;
  logic [cprc_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic [cprc_pkg::SumW-1:0]        dvd_q, dvd_d;
  logic [9:0]                       rem_q, rem_d;
  logic [8:0]                       div_q, div_d;
  logic                             neg_q, neg_d;
  logic                             found_q, found_d;
  logic                             out_valid_q, out_valid_d;
  logic                             out_found_q, out_found_d;
  logic [9:0]                       out_pos_q, out_pos_d;
  logic [8:0]                       out_count_q, out_count_d;
  logic [9:0]                       trial;
  logic                             ge;
  logic [cprc_pkg::SumW-1:0]        quo;
  logic                             out_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    neg_d       = neg_q;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_count_d = out_count_q;
    q_pop_o     = 1'b0;
    trial       = {rem_q[8:0], dvd_q[cprc_pkg::SumW-1]};
    ge          = trial >= {1'b0, div_q};
    quo         = neg_q ? (~dvd_q + 1'b1) : dvd_q;
    out_free    = !out_valid_q || pop_i;

    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      cprc_pkg::BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          neg_d   = q_data_i.sum[cprc_pkg::SumW-1];
          dvd_d   = q_data_i.sum[cprc_pkg::SumW-1] ? (~q_data_i.sum + 1'b1) : q_data_i.sum;
          rem_d   = '0;
          div_d   = q_data_i.tally;
          found_d = q_data_i.found;
          cnt_d   = '0;
          state_d = cprc_pkg::BkDivide;
        end
      end
      cprc_pkg::BkDivide: begin
        rem_d = ge ? (trial - {1'b0, div_q}) : trial;
        dvd_d = {dvd_q[cprc_pkg::SumW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == cprc_pkg::DivCntW'(cprc_pkg::DivSteps - 1)) begin
          state_d = cprc_pkg::BkDone;
        end
      end
      cprc_pkg::BkDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_pos_d   = found_q ? quo[9:0] : '0;
          out_count_d = div_q;
          state_d     = cprc_pkg::BkIdle;
        end
      end
      default: begin
        state_d = cprc_pkg::BkIdle;
      end
    endcase

    empty_o       = !out_valid_q;
    found_o       = out_found_q;
    position_o    = out_pos_q;
    match_count_o = out_count_q;
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    neg_q       <= neg_d;
    found_q     <= found_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_count_q <= out_count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cprc_pkg::BkIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CPRC_ASSERT(a_div_count_range,
    (state_q == cprc_pkg::BkDivide) |-> (cnt_q < cprc_pkg::DivCntW'(cprc_pkg::DivSteps)))
  `CPRC_ASSERT(a_rem_below_divisor,
    (state_q == cprc_pkg::BkDivide && div_q != 9'd0) |-> (rem_q < {1'b0, div_q}))
  `CPRC_ASSERT(a_no_position_without_find,
    (out_valid_q && !out_found_q) |-> (out_pos_q == 10'd0))
  `CPRC_NEVER(a_no_pop_while_busy,
    q_pop_o && (state_q != cprc_pkg::BkIdle))

endmodule
`default_nettype wire

>>> rtl/core/classified_pixel_row_centroid.sv
// A row-end word's totals pass through the queue, the divider and the result register to the result ports.
// Throughput: one pixel word per cycle while full is low; the divider takes one row total at a time.
// The divider works one quotient bit per cycle, 18 steps for the 18-bit offset sum.
// Two row totals may wait in the queue ahead of the divider before full rises.
// Reset clears the row totals, empties the queue and the result word; registers take defaults.
`default_nettype none
module classified_pixel_row_centroid (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cprc_pkg::AddrW-1:0]    paddr,
  input  wire logic [cprc_pkg::DataW-1:0]    pwdata,
  output logic [cprc_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  input  wire logic [7:0]                    luma_i,
  input  wire logic [8:0]                    column_i,
  input  wire logic                          row_end_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               found_o,
  output logic signed [9:0]                  position_o,
  output logic [8:0]                         match_count_o
);

  cprc_pkg::cfg_t     cfg_q, cfg_d;
  logic               wr_en;
  logic [2:0]         reg_idx;
  logic               accept;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  cprc_pkg::row_sum_t q_in;
  cprc_pkg::row_sum_t q_out;

  always_comb begin
    pready  = 1'b1;
    wr_en   = psel && penable && pwrite;
    reg_idx = paddr[4:2];
    cfg_d   = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        cprc_pkg::RegMode:      cfg_d.mode       = cprc_pkg::mode_e'(pwdata[1:0]);
        cprc_pkg::RegDarkThr:   cfg_d.dark_thr   = pwdata[7:0];
        cprc_pkg::RegRedThr:    cfg_d.red_thr    = pwdata[7:0];
        cprc_pkg::RegGreenThr:  cfg_d.green_thr  = pwdata[7:0];
        cprc_pkg::RegBlueThr:   cfg_d.blue_thr   = pwdata[7:0];
        cprc_pkg::RegMinCount:  cfg_d.min_count  = pwdata[8:0];
        cprc_pkg::RegCenterCol: cfg_d.center_col = pwdata[8:0];
        default:                cfg_d            = cfg_q;
      endcase
    end
    unique case (reg_idx)
      cprc_pkg::RegMode:      prdata = {30'd0, cfg_q.mode};
      cprc_pkg::RegDarkThr:   prdata = {24'd0, cfg_q.dark_thr};
      cprc_pkg::RegRedThr:    prdata = {24'd0, cfg_q.red_thr};
      cprc_pkg::RegGreenThr:  prdata = {24'd0, cfg_q.green_thr};
      cprc_pkg::RegBlueThr:   prdata = {24'd0, cfg_q.blue_thr};
      cprc_pkg::RegMinCount:  prdata = {23'd0, cfg_q.min_count};
      cprc_pkg::RegCenterCol: prdata = {23'd0, cfg_q.center_col};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= cprc_pkg::ModeDark;
      cfg_q.dark_thr   <= cprc_pkg::DarkThrReset;
      cfg_q.red_thr    <= cprc_pkg::RedThrReset;
      cfg_q.green_thr  <= cprc_pkg::GreenThrReset;
      cfg_q.blue_thr   <= cprc_pkg::BlueThrReset;
      cfg_q.min_count  <= cprc_pkg::MinCountReset;
      cfg_q.center_col <= cprc_pkg::CenterColReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign accept = push && !full;

  cprc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .luma_i    (luma_i),
    .column_i  (column_i),
    .row_end_i (row_end_i),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  cprc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  cprc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_out),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .found_o       (found_o),
    .position_o    (position_o),
    .match_count_o (match_count_o)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the classified pixel row centroid block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] RegUnused   = 3'd7;
  localparam int         OffsetHigh  = (1 << (cprc_pkg::SumW - 1)) - 1;
  localparam int         OffsetLow   = -(1 << (cprc_pkg::SumW - 1));
  localparam int         SettleCycles = 40;
  localparam int         HoldCycles  = 400;
  localparam int         ShortRowWords = 90;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] luma;
    logic [8:0] column;
    logic       row_end;
  } pixel_t;

  typedef struct packed {
    logic              found;
    logic signed [9:0] position;
    logic [8:0]        match_count;
  } row_result_t;

  class row_centroid_tracker;
    cprc_pkg::cfg_t cfg;
    int             match_tally;
    int             offset_sum;
    row_result_t    pending_rows[$];
    int             mismatches;

    function new();
      cfg = '{cprc_pkg::ModeDark, cprc_pkg::DarkThrReset, cprc_pkg::RedThrReset,
              cprc_pkg::GreenThrReset, cprc_pkg::BlueThrReset,
              cprc_pkg::MinCountReset, cprc_pkg::CenterColReset};
      match_tally = 0;
      offset_sum = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        cprc_pkg::RegMode:      cfg.mode = cprc_pkg::mode_e'(value[1:0]);
        cprc_pkg::RegDarkThr:   cfg.dark_thr = value[7:0];
        cprc_pkg::RegRedThr:    cfg.red_thr = value[7:0];
        cprc_pkg::RegGreenThr:  cfg.green_thr = value[7:0];
        cprc_pkg::RegBlueThr:   cfg.blue_thr = value[7:0];
        cprc_pkg::RegMinCount:  cfg.min_count = value[8:0];
        cprc_pkg::RegCenterCol: cfg.center_col = value[8:0];
        default: ;
      endcase
    endfunction

    function bit outshines(int lead, int thr, int a, int b);
      return lead > thr && 2 * lead > 3 * a && 2 * lead > 3 * b;
    endfunction

    function bit classify_hit(pixel_t px);
      case (cfg.mode)
        cprc_pkg::ModeDark:  return px.luma < cfg.dark_thr;
        cprc_pkg::ModeRed:   return outshines(px.red, cfg.red_thr, px.green, px.blue);
        cprc_pkg::ModeGreen: return outshines(px.green, cfg.green_thr, px.red, px.blue);
        default:   return px.blue > cfg.blue_thr && px.blue > px.red && px.blue > px.green;
      endcase
    endfunction

    function void take_pixel(pixel_t px);
      int          step_sum;
      row_result_t res;
      if (classify_hit(px) && match_tally < cprc_pkg::TallyCap) begin
        step_sum = offset_sum + int'(px.column) - int'(cfg.center_col);
        if (step_sum > OffsetHigh) step_sum = OffsetHigh;
        if (step_sum < OffsetLow) step_sum = OffsetLow;
        offset_sum = step_sum;
        match_tally++;
      end
      if (px.row_end) begin
        res.found = match_tally > int'(cfg.min_count);
        res.position = res.found ? 10'(offset_sum / match_tally) : 10'sd0;
        res.match_count = 9'(match_tally);
        pending_rows.push_back(res);
        match_tally = 0;
        offset_sum = 0;
      end
    endfunction

    function void compare_row(logic found, logic signed [9:0] position, logic [8:0] count);
      row_result_t exp_row;
      if (pending_rows.size() == 0) begin
        $error("row result with no row pending: found %0d position %0d match_count %0d",
               found, position, count);
        mismatches++;
        return;
      end
      exp_row = pending_rows.pop_front();
      if (found !== exp_row.found) begin
        $error("found: expected %0d, actual %0d", exp_row.found, found);
        mismatches++;
      end
      if (position !== exp_row.position) begin
        $error("position: expected %0d, actual %0d", exp_row.position, position);
        mismatches++;
      end
      if (count !== exp_row.match_count) begin
        $error("match_count: expected %0d, actual %0d", exp_row.match_count, count);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_rows.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [cprc_pkg::AddrW-1:0]     paddr = '0;
  logic [cprc_pkg::DataW-1:0]     pwdata = '0;
  logic [cprc_pkg::DataW-1:0]     prdata;
  logic                           pready;
  logic                           push = 1'b0;
  logic                           full;
  logic [7:0]                     red_i = '0;
  logic [7:0]                     green_i = '0;
  logic [7:0]                     blue_i = '0;
  logic [7:0]                     luma_i = '0;
  logic [8:0]                     column_i = '0;
  logic                           row_end_i = 1'b0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic                           found_o;
  logic signed [9:0]              position_o;
  logic [8:0]                     match_count_o;

  row_centroid_tracker tracker = new();
  bit                  hold_off_request = 1'b0;
  int                  burst_left = 0;

  classified_pixel_row_centroid DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .luma_i        (luma_i),
    .column_i      (column_i),
    .row_end_i     (row_end_i),
    .empty         (empty),
    .pop           (pop),
    .found_o       (found_o),
    .position_o    (position_o),
    .match_count_o (match_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("classified_pixel_row_centroid regression: fail");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
  endtask

  function automatic logic [31:0] with_noise(input logic [31:0] value, input int width);
    return ($urandom << width) | value;
  endfunction

  task automatic apply_settings(input cprc_pkg::cfg_t c);
    write_reg(cprc_pkg::RegMode, with_noise(32'(c.mode), 2));
    write_reg(cprc_pkg::RegDarkThr, with_noise(32'(c.dark_thr), 8));
    write_reg(cprc_pkg::RegRedThr, with_noise(32'(c.red_thr), 8));
    write_reg(cprc_pkg::RegGreenThr, with_noise(32'(c.green_thr), 8));
    write_reg(cprc_pkg::RegBlueThr, with_noise(32'(c.blue_thr), 8));
    write_reg(cprc_pkg::RegMinCount, with_noise(32'(c.min_count), 9));
    write_reg(cprc_pkg::RegCenterCol, with_noise(32'(c.center_col), 9));
    write_reg(RegUnused, $urandom);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic offer_pixel(input pixel_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    push <= 1'b1;
    red_i <= px.red;
    green_i <= px.green;
    blue_i <= px.blue;
    luma_i <= px.luma;
    column_i <= px.column;
    row_end_i <= px.row_end;
    do @(posedge clk_i); while (full);
    tracker.take_pixel(px);
  endtask

  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] thresholdish();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(20, 200));
    endcase
  endfunction

  function automatic cprc_pkg::cfg_t random_settings();
    cprc_pkg::cfg_t c;
    c.mode = cprc_pkg::mode_e'($urandom_range(0, 3));
    c.dark_thr = thresholdish();
    c.red_thr = thresholdish();
    c.green_thr = thresholdish();
    c.blue_thr = thresholdish();
    case ($urandom_range(0, 7))
      0: c.min_count = 9'd320;
      1: c.min_count = 9'd0;
      default: c.min_count = 9'($urandom_range(0, 12));
    endcase
    case ($urandom_range(0, 15))
      0, 1: c.center_col = 9'd0;
      2, 3: c.center_col = 9'd319;
      4: c.center_col = 9'($urandom_range(0, 511));
      default: c.center_col = 9'($urandom_range(100, 220));
    endcase
    return c;
  endfunction

  function automatic pixel_t random_pixel(input bit last);
    pixel_t px;
    int     lead;
    px.red = 8'($urandom_range(0, 255));
    px.green = 8'($urandom_range(0, 255));
    px.blue = 8'($urandom_range(0, 255));
    px.luma = 8'($urandom_range(0, 255));
    px.column = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511)) :
                                              9'($urandom_range(0, 319));
    px.row_end = last;
    if ($urandom_range(0, 1) == 1) begin
      lead = $urandom_range(100, 255);
      case (tracker.cfg.mode)
        cprc_pkg::ModeDark: px.luma = 8'($urandom_range(0, tracker.cfg.dark_thr));
        cprc_pkg::ModeRed: begin
          px.red = 8'(lead);
          px.green = 8'($urandom_range(0, lead * 2 / 3));
          px.blue = 8'($urandom_range(0, lead * 2 / 3));
        end
        cprc_pkg::ModeGreen: begin
          px.green = 8'(lead);
          px.red = 8'($urandom_range(0, lead * 2 / 3));
          px.blue = 8'($urandom_range(0, lead * 2 / 3));
        end
        default: begin
          px.blue = 8'(lead);
          px.red = 8'($urandom_range(0, lead));
          px.green = 8'($urandom_range(0, lead));
        end
      endcase
    end
    return px;
  endfunction

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++) offer_pixel(random_pixel(i == len - 1));
  endtask

  // Every pixel of the row matches, which drives the offset sum into saturation and,
  // for a row longer than the cap, the count into its cap.
  task automatic send_long_row(input cprc_pkg::cfg_t c, input int len, input int col_lo,
                               input int col_hi);
    pixel_t px;
    settle();
    apply_settings(c);
    for (int i = 0; i < len; i++) begin
      px = random_pixel(i == len - 1);
      px.luma = 8'($urandom_range(0, 254));
      px.column = 9'($urandom_range(col_lo, col_hi));
      offer_pixel(px);
    end
  endtask

  initial begin
    int pressure;

    int short_words;
    int phase;
    int target;
    int words;
    int len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: dark line, threshold 60, min count 5, center 160.
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 1'b0});
    offer_pixel('{8'd255, 8'd255, 8'd255, 8'd59, 9'd319, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd59, 9'd511, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd59, 9'd160, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd60, 9'd1, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd59, 9'd1, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd30, 9'd256, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd255, 9'd511, 1'b1});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 9'd7, 1'b1});
    settle();

    apply_settings('{cprc_pkg::ModeRed, 8'd60, 8'd0, 8'd60, 8'd70, 9'd0, 9'd0});
    offer_pixel('{8'd255, 8'd0, 8'd0, 8'd0, 9'd300, 1'b0});
    offer_pixel('{8'd3, 8'd2, 8'd0, 8'd0, 9'd10, 1'b0});
    offer_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 9'd10, 1'b0});
    offer_pixel('{8'd255, 8'd170, 8'd0, 8'd0, 9'd10, 1'b0});
    offer_pixel('{8'd255, 8'd169, 8'd169, 8'd0, 9'd3, 1'b1});
    settle();

    apply_settings('{cprc_pkg::ModeGreen, 8'd0, 8'd255, 8'd255, 8'd255, 9'd320, 9'd319});
    offer_pixel('{8'd0, 8'd255, 8'd0, 8'd255, 9'd0, 1'b0});
    offer_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 9'd319, 1'b1});
    settle();

    apply_settings('{cprc_pkg::ModeBlue, 8'd255, 8'd0, 8'd0, 8'd0, 9'd0, 9'd319});
    offer_pixel('{8'd0, 8'd0, 8'd1, 8'd0, 9'd0, 1'b0});
    offer_pixel('{8'd5, 8'd0, 8'd5, 8'd0, 9'd0, 1'b0});
    offer_pixel('{8'd5, 8'd5, 8'd6, 8'd0, 9'd1, 1'b0});
    offer_pixel('{8'd255, 8'd255, 8'd255, 8'd0, 9'd2, 1'b1});

    short_words = 0;
    phase = 0;
    while (short_words < ShortRowWords) begin
      settle();
      apply_settings(random_settings());
      pressure = (phase == 0);
      if (pressure) hold_off_request = 1'b1;
      target = pressure ? 40 : $urandom_range(10, 30);
      words = 0;
      while (words < target) begin
        if (pressure) len = $urandom_range(1, 2);
        else len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 16);
        send_row(len);
        words += len;
      end
      short_words += words;
      if (phase == 1) send_long_row('{cprc_pkg::ModeDark, 8'd255, 8'd0, 8'd0, 8'd0, 9'd0,
                                      9'd0}, 330, 500, 511);
      if (phase == 2) send_long_row('{cprc_pkg::ModeDark, 8'd255, 8'd0, 8'd0, 8'd0, 9'd3,
                                      9'd511}, 280, 0, 8);
      phase++;
    end
    settle();

    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("classified_pixel_row_centroid regression: pass");
    else
      $display("classified_pixel_row_centroid regression: fail");
    $finish;
  end

  initial begin
    int unsigned cyc;
    int unsigned style;
    bit          ready;
    cyc = 0;
    style = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (cyc % 48 == 0) style = $urandom_range(0, 3);
        case (style)
          0: ready = 1'b1;
          1: ready = (cyc % 3 != 0);
          2: ready = 1'($urandom_range(0, 1));
          default: ready = (cyc % 8 == 0);
        endcase
        pop <= ready;
        @(posedge clk_i);
        cyc++;
        if (pop && !empty) tracker.compare_row(found_o, position_o, match_count_o);
      end
    end
  end

endmodule
